[src/keyword_stream_spotter_assert.svh]
// ----------------------------------------------------------------------------
// Keyword stream spotter assertion macros
// Shared property macros for the checker that watches the top-level ports.
// ----------------------------------------------------------------------------
`ifndef KEYWORD_STREAM_SPOTTER_ASSERT_SVH
`define KEYWORD_STREAM_SPOTTER_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define KSS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("keyword spotter check failed");

// Next-cycle implication, masked while reset is asserted.
`define KSS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("keyword spotter check failed");

// Next-cycle implication that also holds across reset.
`define KSS_ASSERT_NEXT_ANY(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("keyword spotter check failed");

`endif

[src/kss_pkg.sv]
// ----------------------------------------------------------------------------
// Keyword stream spotter package
// Buffer sizing, keyword table and character helpers.
// ----------------------------------------------------------------------------
package kss_pkg;

    localparam int MAX_KEY_LEN   = 13;
    localparam int KEYWORD_COUNT = 11;
    localparam int TABLE_SIZE    = 11;
    localparam int KW_MAX        = 13;
    localparam int ACTIVE_KW     = (KEYWORD_COUNT > TABLE_SIZE) ? TABLE_SIZE : KEYWORD_COUNT;
    localparam int LEN_W         = $clog2(MAX_KEY_LEN + 1);
    localparam int KIDX_W        = 4;

    typedef logic [8*KW_MAX-1:0] kw_text_t;
    typedef logic [7:0]          char_t;

    // Keywords in alphabetical order; string literals are right-justified.
    localparam kw_text_t KW_TEXT [TABLE_SIZE] = '{
        "crashplease", "debugfiles", "debugmode", "edittheme", "getdifference",
        "loadcolors", "loadlang", "moderate", "testmode", "videoplayer",
        "workmode"
    };
    localparam int KW_LEN [TABLE_SIZE] = '{11, 10, 9, 9, 13, 10, 8, 8, 8, 11, 8};

    // Character i of keyword k, zero past its end.
    function automatic char_t kw_char(input int k, input int i);
        char_t c;
        c = '0;
        if (i < KW_LEN[k]) begin
            c = KW_TEXT[k][8*(KW_LEN[k]-1-i) +: 8];
        end
        return c;
    endfunction

    function automatic char_t to_lower(input char_t c);
        char_t r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

[src/keyword_stream_spotter.sv]
// A result is registered when the scan of an input transfer ends: the scan
// drops one start offset per step, then writes the result. Each item is one
// character, and no new character is taken while a scan is running.
// The next input transfer is taken the cycle after the previous scan ends.
// Reset (aresetn low, synchronous) empties the pending buffer and drops any
// result not yet transferred; buffer contents themselves are not cleared.
// ----------------------------------------------------------------------------
// Keyword stream spotter
// Lowercases each character, appends it to a pending buffer and scans start
// offsets one per cycle, unless a result is stalled, against the keyword table.
// ----------------------------------------------------------------------------
module keyword_stream_spotter
    import kss_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] character
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [4:1] keyword_index, [7:5] zero
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic              state_reg, state_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    char_t             chars_reg [MAX_KEY_LEN];
    logic              m_valid_reg, m_valid_next;
    logic              matched_reg, matched_next;
    logic [KIDX_W-1:0] kidx_reg, kidx_next;

    logic [ACTIVE_KW-1:0] full_hit;
    logic [ACTIVE_KW-1:0] head_hit;
    logic [KIDX_W-1:0]    hit_idx;
    logic                 can_out;
    logic                 s_xfer;
    logic                 do_shift;
    char_t                in_char;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, kidx_reg, matched_reg};
    assign can_out  = !m_valid_reg || m_tready;
    assign in_char  = to_lower(s_tdata);

    // Shared compare unit: the current buffer window against every keyword head.
    always_comb begin
        logic heq;
        for (int k = 0; k < ACTIVE_KW; k++) begin
            heq = 1'b1;
            for (int i = 0; i < MAX_KEY_LEN; i++) begin
                if (i < int'(len_reg) && chars_reg[i] != kw_char(k, i)) begin
                    heq = 1'b0;
                end
            end
            full_hit[k] = heq && (KW_LEN[k] == int'(len_reg));
            head_hit[k] = heq && (KW_LEN[k] >= int'(len_reg));
        end
        hit_idx = '0;
        for (int k = ACTIVE_KW - 1; k >= 0; k--) begin
            if (full_hit[k]) begin
                hit_idx = KIDX_W'(k);
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        len_next     = len_reg;
        m_valid_next = m_valid_reg && !m_tready;
        matched_next = matched_reg;
        kidx_next    = kidx_reg;
        do_shift     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (int'(len_reg) >= MAX_KEY_LEN) begin
                        len_next = LEN_W'(MAX_KEY_LEN);
                    end else begin
                        len_next = len_reg + 1'b1;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (can_out) begin
                    if (len_reg == '0 || (|head_hit)) begin
                        // Either nothing is left or the window is a keyword head.
                        m_valid_next = 1'b1;
                        matched_next = |full_hit;
                        kidx_next    = hit_idx;
                        state_next   = ST_IDLE;
                        if (|full_hit) begin
                            len_next = '0;
                        end
                    end else begin
                        do_shift = 1'b1;
                        len_next = len_reg - 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
        end
        matched_reg <= matched_next;
        kidx_reg    <= kidx_next;
    end

    // Buffer: append on an input transfer, drop the oldest entry on each scan step.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_KEY_LEN; i++) begin
            if (s_xfer) begin
                if (int'(len_reg) >= MAX_KEY_LEN) begin
                    if (i == MAX_KEY_LEN - 1) begin
                        chars_reg[i] <= in_char;
                    end else begin
                        chars_reg[i] <= chars_reg[i+1];
                    end
                end else if (i == int'(len_reg)) begin
                    chars_reg[i] <= in_char;
                end
            end else if (do_shift && i < MAX_KEY_LEN - 1) begin
                chars_reg[i] <= chars_reg[i+1];
            end
        end
    end

endmodule

[src/kss_checker.sv]
// ----------------------------------------------------------------------------
// Keyword stream spotter checker
// Port-level properties of the spotter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "keyword_stream_spotter_assert.svh"

module kss_checker
    import kss_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // A character transfer starts a scan, so the input side closes at once.
    `KSS_ASSERT_NEXT(a_busy_after_in, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A stalled result holds its value.
    `KSS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata))

    // No match reports index zero; a match names an active keyword.
    `KSS_ASSERT_NOW(a_out_code, aclk, aresetn, m_tvalid,
                    m_tdata[7:5] == 3'b000 &&
                    (m_tdata[0] ? (int'(m_tdata[4:1]) < ACTIVE_KW) : (m_tdata[4:1] == 4'd0)))

    // Reset drops any pending result.
    `KSS_ASSERT_NEXT_ANY(a_reset_clear, aclk, !aresetn, !m_tvalid && s_tready)

endmodule

bind keyword_stream_spotter kss_checker u_kss_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
